// ===== hdl/grm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_pkg
// Shared constants, types and the arctangent table of the grid ray marcher.
// ----------------------------------------------------------------------------
package grm_pkg;

  // Grid geometry.
  localparam int MAP_SIDE  = 64;
  localparam int MAP_W     = $clog2(MAP_SIDE);
  localparam int MAP_A_W   = 2 * MAP_W;
  localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;

  // Angles and rotation unit.
  localparam int TURN_UNITS   = 5760;
  localparam int HEAD_W       = 13;
  localparam int ANG_W        = 32;
  localparam int CS_W         = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int CSTEP_W      = 5;
  localparam logic signed [CS_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Divider unit.
  localparam int DIV_NUM_W = 45;
  localparam int DIV_DEN_W = 13;
  localparam int DIV_CNT_W = 6;

  // Ray positions (Q32 cells), steps, offsets (Q16) and squared distances.
  localparam int POS_W  = 42;
  localparam int STEP_W = 36;
  localparam int OFF_W  = 26;
  localparam int D2_W   = 48;
  localparam int DIST_W = 24;
  localparam int SQRT_STEPS = D2_W / 2;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

  localparam int OUT_W = 22;
  localparam logic [OUT_W-1:0] DIST_MAX = {OUT_W{1'b1}};

  // Configuration registers.
  localparam int APB_AW = 3;
  localparam logic REG_STEP_DIV   = 1'b0;
  localparam logic REG_VIEW_LIMIT = 1'b1;
  localparam logic [7:0] STEP_DIV_RESET   = 8'd50;
  localparam logic [5:0] VIEW_LIMIT_RESET = 6'd11;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  // Arctangent of 2^-i as a fraction of a full turn, 32-bit scale.
  function automatic logic [30:0] atan_turn(input logic [CSTEP_W-1:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd536870912;
      5'd1:  v = 31'd316933406;
      5'd2:  v = 31'd167458907;
      5'd3:  v = 31'd85004756;
      5'd4:  v = 31'd42667331;
      5'd5:  v = 31'd21354465;
      5'd6:  v = 31'd10679838;
      5'd7:  v = 31'd5340245;
      5'd8:  v = 31'd2670163;
      5'd9:  v = 31'd1335087;
      5'd10: v = 31'd667544;
      5'd11: v = 31'd333772;
      5'd12: v = 31'd166886;
      5'd13: v = 31'd83443;
      5'd14: v = 31'd41722;
      5'd15: v = 31'd20861;
      5'd16: v = 31'd10430;
      5'd17: v = 31'd5215;
      5'd18: v = 31'd2608;
      5'd19: v = 31'd1304;
      5'd20: v = 31'd652;
      5'd21: v = 31'd326;
      5'd22: v = 31'd163;
      5'd23: v = 31'd81;
      5'd24: v = 31'd41;
      5'd25: v = 31'd20;
      5'd26: v = 31'd10;
      5'd27: v = 31'd5;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/grm_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grm_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [grm_pkg::DIV_NUM_W-1:0] num,
  input  logic [grm_pkg::DIV_DEN_W-1:0] den,
  output grm_pkg::unit_stat_t           stat,
  output logic [grm_pkg::DIV_NUM_W-1:0] quo
);

  logic [grm_pkg::DIV_CNT_W-1:0] cnt;
  logic                          done;
  logic [grm_pkg::DIV_DEN_W-1:0] rem;
  logic [grm_pkg::DIV_DEN_W:0]   rem_sh;
  logic                          take;

  assign rem_sh    = {rem, quo[grm_pkg::DIV_NUM_W-1]};
  assign take      = rem_sh >= {1'b0, den};
  assign stat.busy = cnt != '0;
  assign stat.done = done;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= grm_pkg::DIV_CNT_W'(grm_pkg::DIV_NUM_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == grm_pkg::DIV_CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  // The numerator shifts out of the top of quo while quotient bits enter below.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
    end else if (cnt != '0) begin
      quo <= {quo[grm_pkg::DIV_NUM_W-2:0], take};
      rem <= take ? grm_pkg::DIV_DEN_W'(rem_sh - {1'b0, den})
                  : rem_sh[grm_pkg::DIV_DEN_W-1:0];
    end
  end

endmodule

// ===== hdl/grm_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_cordic
// Iterative rotation unit giving cosine and sine in Q30, one step per cycle.
// ----------------------------------------------------------------------------
module grm_cordic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [grm_pkg::ANG_W-1:0]       angle,
  output grm_pkg::unit_stat_t             stat,
  output logic signed [grm_pkg::CS_W-1:0] cos_v,
  output logic signed [grm_pkg::CS_W-1:0] sin_v
);

  localparam logic signed [grm_pkg::CS_W-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [grm_pkg::CS_W-1:0] HALF    = 34'sd2147483648;

  logic                            busy;
  logic                            done;
  logic [grm_pkg::CSTEP_W-1:0]     i;
  logic signed [grm_pkg::CS_W-1:0] x, y, z;
  logic                            flip;
  logic signed [grm_pkg::CS_W-1:0] z_in, z_fold, xs, ys, at;
  logic                            flip_in;

  always_comb begin
    z_in    = $signed({{(grm_pkg::CS_W-grm_pkg::ANG_W){angle[grm_pkg::ANG_W-1]}}, angle});
    z_fold  = z_in;
    flip_in = 1'b0;
    // Angles beyond a quarter turn are rotated by half a turn and negated after.
    if (z_in > QUARTER) begin
      z_fold  = z_in - HALF;
      flip_in = 1'b1;
    end else if (z_in < -QUARTER) begin
      z_fold  = z_in + HALF;
      flip_in = 1'b1;
    end
  end

  assign xs = x >>> i;
  assign ys = y >>> i;
  assign at = $signed({3'b000, grm_pkg::atan_turn(i)});

  assign stat.busy = busy;
  assign stat.done = done;
  assign cos_v     = flip ? -x : x;
  assign sin_v     = flip ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      i    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        i    <= '0;
      end else if (busy) begin
        if (i == grm_pkg::CSTEP_W'(grm_pkg::CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          i <= i + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= grm_pkg::CORDIC_GAIN;
      y    <= '0;
      z    <= z_fold;
      flip <= flip_in;
    end else if (busy) begin
      if (!z[grm_pkg::CS_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - at;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + at;
      end
    end
  end

endmodule

// ===== hdl/grid_ray_march_distance_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_ray_march_distance_core
// Fixed-step ray march over a one-bit grid with fisheye-corrected distance.
// ----------------------------------------------------------------------------
// The input stream carries requests; s_tuser selects the operation. A cell
// write (s_tuser 0) updates the 64 x 64 grid in the cycle it is accepted and
// yields no result. A ray request (s_tuser 1) yields one result item:
// m_tdata holds the corrected distance in Q6.16, m_tuser is set when the ray
// stopped on a wall cell. Cells outside the grid read as wall.
// A ray marches for at most about view_limit * step_divisor steps. Each
// march step reads the grid memory and then runs the wall and range test;
// besides the march, a ray takes two divisions, two rotations and a square
// root. One request is in flight at a time. The finished result sits in an
// output register, so the next request is taken while m_tready is low; a
// ray that finishes while the previous result is still waiting holds until
// it is taken. After reset the grid is cleared one cell per cycle, all
// 4096 cells, and s_tready stays low until then; APB writes are taken
// throughout.
// ----------------------------------------------------------------------------
module grid_ray_march_distance_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // cell_x[5:0], cell_y[11:6], cell_is_wall[12], player_x[34:13],
  // player_y[56:35], ray_heading[69:57], view_heading[82:70], zero pad
  input  logic [87:0]                 s_tdata,
  input  logic                        s_tuser,   // op
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [23:0]                 m_tdata,   // corrected_distance[21:0], zero pad
  output logic                        m_tuser,   // hit_wall
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grm_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  typedef enum logic [10:0] {
    ST_CLEAR     = 11'b00000000001,
    ST_IDLE      = 11'b00000000010,
    ST_COS_RAY   = 11'b00000000100,
    ST_DIV_X     = 11'b00000001000,
    ST_DIV_Y     = 11'b00000010000,
    ST_ADDR      = 11'b00000100000,
    ST_TEST      = 11'b00001000000,
    ST_SQRT      = 11'b00010000000,
    ST_COS_VIEW  = 11'b00100000000,
    ST_MUL       = 11'b01000000000,
    ST_OUT       = 11'b10000000000
  } state_t;

  localparam logic [grm_pkg::HEAD_W-1:0] TURN = grm_pkg::HEAD_W'(grm_pkg::TURN_UNITS);
  localparam logic signed [grm_pkg::POS_W-1:0] HALF_CELL =
    grm_pkg::POS_W'(64'h8000_0000);
  localparam logic [19:0] TURN_STEP     = 20'd745654;
  localparam logic [14:0] TURN_FRAC_MUL = 15'd23302;

  // round(h * 2^32 / 5760) equals floor((h * 2^25 + 22) / 45). Since
  // 2^25 = 45 * 745654 + 2, that is h * 745654 plus (2h + 22) / 45, and the
  // small quotient comes from a reciprocal multiplication.
  function automatic logic [grm_pkg::ANG_W-1:0] heading_turn(
    input logic [grm_pkg::HEAD_W-1:0] h);
    logic [grm_pkg::ANG_W-1:0] whole;
    logic [14:0]               num;
    logic [29:0]               frac;
    whole = grm_pkg::ANG_W'(h) * grm_pkg::ANG_W'(TURN_STEP);
    num   = {1'b0, h, 1'b0} + 15'd22;
    frac  = 30'(num) * 30'(TURN_FRAC_MUL);
    return whole + grm_pkg::ANG_W'(frac[29:20]);
  endfunction

  state_t state;

  // Configuration.
  logic [7:0] step_div;
  logic [5:0] view_limit;
  logic       cfg_we;

  // Input fields.
  logic [5:0]                  in_cx, in_cy;
  logic                        in_wall;
  logic [21:0]                 in_px, in_py;
  logic [grm_pkg::HEAD_W-1:0]  in_rh, in_vh, rh_mod, vh_mod, diff_mod;
  logic [grm_pkg::HEAD_W:0]    diff_raw;
  logic                        in_acc;

  // Grid memory.
  logic                        map_mem [grm_pkg::MAP_DEPTH];
  logic                        map_q;
  logic                        mem_we, mem_wd;
  logic [grm_pkg::MAP_A_W-1:0] mem_waddr, mem_raddr, clr_cnt;
  logic [8:0]                  wcx, wcy;
  logic                        wr_in_grid;

  // Shared units.
  logic                                 div_start, cor_start;
  logic [grm_pkg::DIV_NUM_W-1:0]        div_num, div_quo;
  logic [grm_pkg::DIV_DEN_W-1:0]        div_den;
  grm_pkg::unit_stat_t                  div_stat, cor_stat;
  logic [grm_pkg::ANG_W-1:0]            cor_angle;
  logic signed [grm_pkg::CS_W-1:0]      cor_cos, cor_sin;

  // Ray data path.
  logic [grm_pkg::HEAD_W-1:0]           diff_q;
  logic                                 sin_neg, cos_neg;
  logic [grm_pkg::CS_W-1:0]             sin_mag, cos_mag, sin_mag_hold;
  logic signed [grm_pkg::STEP_W-1:0]    stx, sty, q_step;
  logic signed [grm_pkg::POS_W-1:0]     sx, sy, rx, ry, offx, offy;
  logic signed [grm_pkg::OFF_W-1:0]     dx, dy;
  logic signed [2*grm_pkg::OFF_W-1:0]   dx2, dy2;
  logic [grm_pkg::D2_W-1:0]             sqx, sqy, d2_now, lim2, sq_v, sq_r, sq_bit, sq_sum;
  logic [11:0]                          vl_sq;
  logic                                 outside, wall_now, hit;
  logic [grm_pkg::SQRT_CNT_W-1:0]       sq_cnt;
  logic [grm_pkg::DIST_W-1:0]           ray_len;
  logic                                 cv_pos;
  logic [30:0]                          cv_mag;
  logic [grm_pkg::DIST_W+30:0]          prod;
  logic [grm_pkg::DIST_W+31:0]          prod_rnd;
  logic [grm_pkg::DIST_W+1:0]           res_full;
  logic [grm_pkg::OUT_W-1:0]            res;

  assign in_cx   = s_tdata[5:0];
  assign in_cy   = s_tdata[11:6];
  assign in_wall = s_tdata[12];
  assign in_px   = s_tdata[34:13];
  assign in_py   = s_tdata[56:35];
  assign in_rh   = s_tdata[69:57];
  assign in_vh   = s_tdata[82:70];

  assign s_tready = state == ST_IDLE;
  assign in_acc   = s_tvalid && s_tready;
  assign pready   = 1'b1;

  // ---------------------------------------------------------------- APB
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_div   <= grm_pkg::STEP_DIV_RESET;
      view_limit <= grm_pkg::VIEW_LIMIT_RESET;
    end else if (cfg_we) begin
      case (paddr[2])
        grm_pkg::REG_STEP_DIV:   step_div   <= pwdata[7:0];
        grm_pkg::REG_VIEW_LIMIT: view_limit <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      grm_pkg::REG_STEP_DIV:   prdata = {24'd0, step_div};
      grm_pkg::REG_VIEW_LIMIT: prdata = {26'd0, view_limit};
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- headings
  always_comb begin
    rh_mod   = (in_rh >= TURN) ? in_rh - TURN : in_rh;
    vh_mod   = (in_vh >= TURN) ? in_vh - TURN : in_vh;
    diff_raw = {1'b0, rh_mod} + {1'b0, TURN} - {1'b0, vh_mod};
    diff_mod = (diff_raw >= {1'b0, TURN}) ? grm_pkg::HEAD_W'(diff_raw - {1'b0, TURN})
                                          : diff_raw[grm_pkg::HEAD_W-1:0];
  end

  // ---------------------------------------------------------------- grid memory
  assign wcx        = 9'(in_cx);
  assign wcy        = 9'(in_cy);
  assign wr_in_grid = (wcx < 9'(grm_pkg::MAP_SIDE)) && (wcy < 9'(grm_pkg::MAP_SIDE));

  always_comb begin
    mem_we    = 1'b0;
    mem_wd    = 1'b0;
    mem_waddr = clr_cnt;
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (in_acc && !s_tuser && wr_in_grid) begin
      mem_we    = 1'b1;
      mem_wd    = in_wall;
      mem_waddr = {wcy[grm_pkg::MAP_W-1:0], wcx[grm_pkg::MAP_W-1:0]};
    end
  end

  assign mem_raddr = {ry[32 +: grm_pkg::MAP_W], rx[32 +: grm_pkg::MAP_W]};

  // The read result is used only while marching, and writes happen only during
  // the clear and when idle, so a write never meets a read that is used.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wd;
    end
    map_q <= map_mem[mem_raddr];
  end

  // ---------------------------------------------------------------- units
  grm_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quo   (div_quo)
  );

  grm_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .angle (cor_angle),
    .stat  (cor_stat),
    .cos_v (cor_cos),
    .sin_v (cor_sin)
  );

  // ---------------------------------------------------------------- march path
  assign offx = rx - sx;
  assign offy = ry - sy;
  assign dx   = grm_pkg::OFF_W'(offx >>> 16);
  assign dy   = grm_pkg::OFF_W'(offy >>> 16);
  assign dx2  = dx * dx;
  assign dy2  = dy * dy;

  assign vl_sq    = 6'(view_limit) * 6'(view_limit) + 12'd0;
  assign lim2     = {4'd0, vl_sq, 32'd0};
  assign d2_now   = sqx + sqy;
  assign wall_now = outside || map_q;

  assign sq_sum = sq_r + sq_bit;

  assign cos_neg = cor_cos[grm_pkg::CS_W-1];
  assign sin_neg = cor_sin[grm_pkg::CS_W-1];
  assign cos_mag = cos_neg ? grm_pkg::CS_W'(-cor_cos) : grm_pkg::CS_W'(cor_cos);
  assign sin_mag = sin_neg ? grm_pkg::CS_W'(-cor_sin) : grm_pkg::CS_W'(cor_sin);
  assign q_step  = $signed(div_quo[grm_pkg::STEP_W-1:0]);

  assign prod_rnd = {1'b0, prod} + (grm_pkg::DIST_W+32)'(64'h2000_0000);
  assign res_full = prod_rnd[grm_pkg::DIST_W+31:30];
  assign res      = !cv_pos ? '0 :
                    (res_full > (grm_pkg::DIST_W+2)'(grm_pkg::DIST_MAX)) ? grm_pkg::DIST_MAX :
                    res_full[grm_pkg::OUT_W-1:0];

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      div_start <= 1'b0;
      cor_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      cor_start <= 1'b0;
      if (m_tvalid && m_tready && state != ST_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == grm_pkg::MAP_A_W'(grm_pkg::MAP_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc && s_tuser) begin
            cor_start <= 1'b1;
            state     <= ST_COS_RAY;
          end
        end
        ST_COS_RAY: begin
          if (cor_stat.done) begin
            div_start <= 1'b1;
            state     <= ST_DIV_X;
          end
        end
        ST_DIV_X: begin
          if (div_stat.done) begin
            div_start <= 1'b1;
            state     <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          if (div_stat.done) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          state <= ST_TEST;
        end
        ST_TEST: begin
          state <= (wall_now || d2_now >= lim2) ? ST_SQRT : ST_ADDR;
        end
        ST_SQRT: begin
          if (sq_cnt == grm_pkg::SQRT_CNT_W'(1)) begin
            cor_start <= 1'b1;
            state     <= ST_COS_VIEW;
          end
        end
        ST_COS_VIEW: begin
          if (cor_stat.done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- data path
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        diff_q    <= diff_mod;
        sx        <= $signed({4'd0, in_px, 16'd0}) + HALF_CELL;
        sy        <= $signed({4'd0, in_py, 16'd0}) + HALF_CELL;
        rx        <= $signed({4'd0, in_px, 16'd0}) + HALF_CELL;
        ry        <= $signed({4'd0, in_py, 16'd0}) + HALF_CELL;
        cor_angle <= heading_turn(rh_mod);
      end
      ST_COS_RAY: begin
        cv_pos  <= cos_neg;
        cv_mag  <= sin_neg ? 31'd1 : 31'd0;
        sin_mag_hold <= sin_mag;
        div_num <= grm_pkg::DIV_NUM_W'({cos_mag, 2'b00});
        div_den <= grm_pkg::DIV_DEN_W'((step_div == 8'd0) ? 8'd1 : step_div);
      end
      ST_DIV_X: begin
        // Quotient of the magnitude; the sign comes back afterwards.
        stx     <= cv_pos ? -q_step : q_step;
        div_num <= grm_pkg::DIV_NUM_W'({sin_mag_hold, 2'b00});
      end
      ST_DIV_Y: begin
        sty <= cv_mag[0] ? -q_step : q_step;
      end
      ST_ADDR: begin
        sqx     <= dx2[grm_pkg::D2_W-1:0];
        sqy     <= dy2[grm_pkg::D2_W-1:0];
        outside <= rx[grm_pkg::POS_W-1] || ry[grm_pkg::POS_W-1] ||
                   (rx[grm_pkg::POS_W-2:32] >= (grm_pkg::POS_W-33)'(grm_pkg::MAP_SIDE)) ||
                   (ry[grm_pkg::POS_W-2:32] >= (grm_pkg::POS_W-33)'(grm_pkg::MAP_SIDE));
      end
      ST_TEST: begin
        hit    <= wall_now;
        sq_v   <= d2_now;
        sq_r   <= '0;
        sq_bit <= grm_pkg::D2_W'(1) << (grm_pkg::D2_W - 2);
        sq_cnt <= grm_pkg::SQRT_CNT_W'(grm_pkg::SQRT_STEPS);
        rx     <= rx + grm_pkg::POS_W'(stx);
        ry     <= ry + grm_pkg::POS_W'(sty);
      end
      ST_SQRT: begin
        if (sq_v >= sq_sum) begin
          sq_v    <= sq_v - sq_sum;
          sq_r    <= (sq_r >> 1) + sq_bit;
          ray_len <= grm_pkg::DIST_W'((sq_r >> 1) + sq_bit);
        end else begin
          sq_r    <= sq_r >> 1;
          ray_len <= grm_pkg::DIST_W'(sq_r >> 1);
        end
        sq_bit    <= sq_bit >> 2;
        sq_cnt    <= sq_cnt - 1'b1;
        cor_angle <= heading_turn(diff_q);
      end
      ST_COS_VIEW: begin
        cv_pos <= !cor_cos[grm_pkg::CS_W-1] && (cor_cos != '0);
        cv_mag <= cor_cos[30:0];
      end
      ST_MUL: begin
        prod <= ray_len * cv_mag;
      end
      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= {2'b00, res};
          m_tuser <= hit;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/grm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_checker
// Port-level checks of the ray marcher, bound to the top level.
// ----------------------------------------------------------------------------
module grm_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata
);

  // A waiting result is neither dropped nor changed.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // The grid is being cleared right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken during grid clear");

  // A ray occupies the block, so no second request follows at once.
  a_ray_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("request taken while a ray is marching");

  // A cell write never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !s_tuser |=> !$rose(m_tvalid))
    else $error("result appeared after a cell write");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[23:22] == 2'b00)
    else $error("result padding not zero");

endmodule

bind grid_ray_march_distance_core grm_port_checks u_grm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== bench/grm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grm_checker
// Watches the request, result and register ports of the ray marcher,
// predicts every ray result and compares it with what the block returns.
// ----------------------------------------------------------------------------
// The checker keeps its own copy of the grid and of both registers. It
// follows accepted cell writes and APB writes. Each accepted ray request
// pushes one predicted distance and wall flag. Each accepted result is
// compared with the oldest prediction.
// ----------------------------------------------------------------------------
module grm_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [87:0]                 s_tdata,
  input  logic                        s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [23:0]                 m_tdata,
  input  logic                        m_tuser,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [grm_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending,
  output int                          rays_seen,
  output int                          hits_seen,
  output int                          writes_seen
);

  localparam longint TURN = 5760;
  localparam longint GAIN = 652032874;
  localparam longint ATAN [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  typedef struct {
    logic [21:0] distance;
    logic        hit;
  } ray_result_t;

  logic        grid [grm_pkg::MAP_DEPTH];
  logic [7:0]  step_div;
  logic [5:0]  view_lim;
  ray_result_t ray_result_q [$];

  assign pending = ray_result_q.size();

  function automatic longint heading_to_turn(input longint h);
    return (((h % TURN) << 32) + TURN / 2) / TURN;
  endfunction

  // Rotation of the gain vector; angles beyond a quarter turn are mirrored.
  function automatic void rotate(input longint turn, output longint c,
                                 output longint s);
    longint z, x, y, nx;
    bit     flip;
    z = turn;
    x = GAIN;
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= ATAN[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += ATAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic bit blocked(input longint px, input longint py);
    longint ix, iy;
    if (px < 0 || py < 0) return 1;
    ix = px >>> 32;
    iy = py >>> 32;
    if (ix >= grm_pkg::MAP_SIDE || iy >= grm_pkg::MAP_SIDE) return 1;
    return grid[iy * grm_pkg::MAP_SIDE + ix];
  endfunction

  function automatic longint floor_sqrt(input longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic ray_result_t march_ray(input logic [87:0] req);
    longint      rh, vh, cr, sr, cv, sv, div, stx, sty, sx, sy, rx, ry;
    longint      dx, dy, d2, lim, lim2, ray_len, res;
    ray_result_t r;
    div = (step_div == 0) ? 1 : step_div;
    rh = req[69:57] % TURN;
    vh = req[82:70] % TURN;
    rotate(heading_to_turn(rh), cr, sr);
    stx = (cr * 4) / div;
    sty = (sr * 4) / div;
    sx = (longint'(req[34:13]) << 16) + 64'sd2147483648;
    sy = (longint'(req[56:35]) << 16) + 64'sd2147483648;
    rx = sx;
    ry = sy;
    lim = longint'(view_lim) << 16;
    lim2 = lim * lim;
    forever begin
      if (blocked(rx, ry)) break;
      dx = (rx - sx) >>> 16;
      dy = (ry - sy) >>> 16;
      if (dx * dx + dy * dy >= lim2) break;
      rx += stx;
      ry += sty;
    end
    r.hit = blocked(rx, ry);
    dx = (rx - sx) >>> 16;
    dy = (ry - sy) >>> 16;
    d2 = dx * dx + dy * dy;
    ray_len = floor_sqrt(d2);
    rotate(heading_to_turn((rh + TURN - vh) % TURN), cv, sv);
    if (cv <= 0) begin
      res = 0;
    end else begin
      res = (ray_len * cv + 64'sd536870912) >>> 30;
      if (res > 4194303) res = 4194303;
    end
    r.distance = res[21:0];
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH at %0t: %s got %0d, predicted %0d", $realtime, what, got, want);
    errors++;
  endtask

  initial begin
    errors = 0;
    rays_seen = 0;
    hits_seen = 0;
    writes_seen = 0;
  end

  always @(posedge clk) begin
    ray_result_t want;
    if (rst) begin
      for (int i = 0; i < grm_pkg::MAP_DEPTH; i++) grid[i] = 1'b0;
      step_div = grm_pkg::STEP_DIV_RESET;
      view_lim = grm_pkg::VIEW_LIMIT_RESET;
      ray_result_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == grm_pkg::REG_VIEW_LIMIT) view_lim = pwdata[5:0];
        else step_div = pwdata[7:0];
      end
      if (m_tvalid && m_tready) begin
        if (ray_result_q.size() == 0) begin
          report("result with no ray request pending, distance", m_tdata[21:0], 0);
        end else begin
          want = ray_result_q.pop_front();
          if (m_tdata[21:0] !== want.distance)
            report("corrected distance", m_tdata[21:0], want.distance);
          if (m_tdata[23:22] !== 2'b00) report("distance pad bits", m_tdata[23:22], 0);
          if (m_tuser !== want.hit) report("wall hit flag", m_tuser, want.hit);
          if (want.hit) hits_seen++;
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == 1'b0) begin
          grid[s_tdata[11:6] * grm_pkg::MAP_SIDE + s_tdata[5:0]] = s_tdata[12];
          writes_seen++;
        end else begin
          ray_result_q.push_back(march_ray(s_tdata));
          rays_seen++;
        end
      end
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the grid ray march distance core.
// ----------------------------------------------------------------------------
// Drives cell writes and ray requests on the input stream under several
// register settings and idle patterns; the checker beside the block predicts
// and compares every result. A watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module testbench;

  localparam int HANG_LIMIT = 200000;
  localparam logic [21:0] MID = 22'd32 << 16;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [87:0]                s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [23:0]                m_tdata;
  logic                       m_tuser;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [grm_pkg::APB_AW-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  int errors, pending, rays_seen, hits_seen, writes_seen;
  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int settings_used = 1;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  grid_ray_march_distance_core u_top (.*);

  grm_checker u_checker (.*);

  always @(negedge clk) m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", HANG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(input logic op, input logic [5:0] cx, input logic [5:0] cy,
                      input logic wall, input logic [21:0] px, input logic [21:0] py,
                      input logic [12:0] rh, input logic [12:0] vh);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {5'b0, vh, rh, py, px, wall, cy, cx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic put_cell(input logic [5:0] cx, input logic [5:0] cy, input logic wall);
    send(1'b0, cx, cy, wall, '0, '0, '0, '0);
  endtask

  task automatic ray(input logic [21:0] px, input logic [21:0] py,
                     input logic [12:0] rh, input logic [12:0] vh);
    send(1'b1, '0, '0, '0, px, py, rh, vh);
  endtask

  // Lets the block finish all outstanding rays with the input stream quiet.
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [7:0] div, input logic [5:0] lim);
    drain();
    reg_write(grm_pkg::REG_STEP_DIV, {$urandom} & 32'hFFFF_FF00 | div);
    reg_write(grm_pkg::REG_VIEW_LIMIT, {$urandom} & 32'hFFFF_FFC0 | lim);
    settings_used++;
  endtask

  function automatic logic [21:0] rand_pos();
    if ($urandom_range(0, 9) < 8) return 22'($urandom_range(0, 64 << 16));
    return 22'($urandom);
  endfunction

  // Mostly rays inside the grid over a map that keeps gaining walls.
  task automatic random_items(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 40)
        put_cell(6'($urandom), 6'($urandom), $urandom_range(0, 9) < 7);
      else
        ray(rand_pos(), rand_pos(), 13'($urandom), 13'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings.
    ray(MID, MID, 13'd0, 13'd0);
    ray(MID, MID, 13'd8191, 13'd0);
    ray(MID, MID, 13'd2880, 13'd0);
    ray(MID, MID, 13'd1440, 13'd4320);
    ray(MID, MID, 13'd5759, 13'd5759);
    ray(22'h3FFFFF, 22'h3FFFFF, 13'd100, 13'd100);
    ray(22'd0, 22'd0, 13'd2880, 13'd2880);
    for (int y = 30; y <= 34; y++) put_cell(6'd36, 6'(y), 1'b1);
    ray(MID, MID, 13'd0, 13'd0);
    ray(MID, MID, 13'd0, 13'd200);
    put_cell(6'd36, 6'd32, 1'b0);
    ray(MID, MID, 13'd0, 13'd0);
    put_cell(6'd63, 6'd63, 1'b1);
    put_cell(6'd0, 6'd0, 1'b1);
    put_cell(6'd0, 6'd0, 1'b0);
    put_cell(6'd63, 6'd0, 1'b1);
    ray(22'd63 << 16, 22'd1 << 16, 13'd0, 13'd0);

    for (int mode = 0; mode < 3; mode++) begin
      send_gap_pct = (mode == 0) ? 10 : (mode == 1) ? 46 : 0;
      recv_gap_pct = (mode == 0) ? 46 : (mode == 1) ? 10 : 0;
      configure(8'd0, 6'd0);
      random_items(10);
      configure(8'd1, 6'd63);
      ray(22'd0, 22'd0, 13'd720, 13'd720);
      random_items(25);
      configure(8'd255, 6'd63);
      random_items(4);
      configure(8'd1, 6'd1);
      random_items(20);
      for (int k = 0; k < 5; k++) begin
        configure(8'($urandom_range(1, 16)), 6'($urandom_range(1, 24)));
        random_items(18);
        if (k == 2) drain();
        random_items(18);
      end
    end
    configure(8'd50, 6'd11);
    random_items(10);

    drain();
    repeat (20) @(posedge clk);
    $display("Run covered %0d cell writes and %0d rays (%0d stopped on a wall)",
             writes_seen, rays_seen, hits_seen);
    $display("over %0d register settings and three idle patterns.", settings_used);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== grid_ray_march_distance_core.f =====
hdl/grm_pkg.sv
hdl/grm_divider.sv
hdl/grm_cordic.sv
hdl/grid_ray_march_distance_core.sv
hdl/grm_checker.sv
bench/grm_checker.sv
bench/testbench.sv
